// ===== sv/assert_macros.svh =====
// assertion macros shared by the scaler rtl
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define BRIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition at one edge implies result at the next
`define BRIS_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

// ===== sv/bris_pkg.sv =====
// constants, types and helpers of the bilinear rgb scaler
// no dependencies
package bris_pkg;

  localparam int SRC_DIM   = 256;
  localparam int SRC_AW    = $clog2(SRC_DIM);
  localparam int BANK_AW   = 2 * (SRC_AW - 1);
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 12;
  localparam int STEP_W    = 24;
  localparam int SIZE_W    = 9;
  localparam int POS_W     = IDX_W + STEP_W;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int E_W       = FRAC_BITS + 2;
  localparam int WT_W      = FRAC_BITS + 4;
  localparam int PIX_W     = 8;
  localparam int PRD_W     = WT_W + PIX_W + 1;
  localparam int SUM_W     = PRD_W + 2;

  typedef enum logic [1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_ROW_STEP      = 2'd2,
    REG_COL_STEP      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_REQUEST = 1'b1
  } action_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // largest usable integer position: effective size minus two
  function automatic logic [SRC_AW-1:0] eff_lim(input logic [SIZE_W-1:0] s);
    logic [SRC_AW-1:0] r;
    if (s < SIZE_W'(2)) begin
      r = '0;
    end else if (s > SIZE_W'(SRC_DIM)) begin
      r = SRC_AW'(SRC_DIM - 2);
    end else begin
      r = SRC_AW'(s - SIZE_W'(2));
    end
    return r;
  endfunction

endpackage

// ===== sv/bris_axis.sv =====
// per-axis position unit: index times step, clamp and fraction
// depends on bris_pkg
module bris_axis (
  input  logic                              clk,
  input  logic                              en,
  input  logic [bris_pkg::IDX_W-1:0]        index,
  input  logic [bris_pkg::STEP_W-1:0]       step,
  input  logic [bris_pkg::SRC_AW-1:0]       lim,
  output logic [bris_pkg::SRC_AW-1:0]       ip,
  output logic [bris_pkg::FRAC_W-1:0]       frac
);

  localparam int IP_W = bris_pkg::POS_W - bris_pkg::FRAC_BITS;

  logic [bris_pkg::POS_W-1:0] pos;
  logic [IP_W-1:0]            ipos;
  logic [IP_W-1:0]            diff;
  logic [bris_pkg::SRC_AW-1:0] ip_next;
  logic [bris_pkg::FRAC_W-1:0] frac_next;

  always_ff @(posedge clk) begin
    if (en) begin
      pos  <= bris_pkg::POS_W'(index) * bris_pkg::POS_W'(step);
      ip   <= ip_next;
      frac <= frac_next;
    end
  end

  always_comb begin
    ipos = pos[bris_pkg::POS_W-1:bris_pkg::FRAC_BITS];
    diff = ipos - IP_W'(lim);
    if (ipos > IP_W'(lim)) begin
      ip_next = lim;
      if (diff >= IP_W'(2)) begin
        frac_next = '1;
      end else begin
        frac_next = {diff[0], pos[bris_pkg::FRAC_BITS-1:0]};
      end
    end else begin
      ip_next   = ipos[bris_pkg::SRC_AW-1:0];
      frac_next = {1'b0, pos[bris_pkg::FRAC_BITS-1:0]};
    end
  end

endmodule

// ===== sv/bris_mem.sv =====
// source image store in four banks by row and column parity
// depends on bris_pkg; one write and one read per bank per cycle
module bris_mem (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          wr_en,
  input  logic [bris_pkg::SRC_AW-1:0]   wr_row,
  input  logic [bris_pkg::SRC_AW-1:0]   wr_col,
  input  bris_pkg::rgb_t                wr_data,
  input  logic [bris_pkg::SRC_AW-1:0]   rd_row,
  input  logic [bris_pkg::SRC_AW-1:0]   rd_col,
  output bris_pkg::rgb_t [3:0]          rd_data
);

  localparam int HW = bris_pkg::SRC_AW - 1;

  logic [HW-1:0] row_even, row_odd, col_even, col_odd;

  always_comb begin
    row_odd  = rd_row[bris_pkg::SRC_AW-1:1];
    row_even = row_odd + HW'(rd_row[0]);
    col_odd  = rd_col[bris_pkg::SRC_AW-1:1];
    col_even = col_odd + HW'(rd_col[0]);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bris_pkg::rgb_t             mem [0:(1 << bris_pkg::BANK_AW)-1];
    logic [bris_pkg::BANK_AW-1:0] rd_addr;
    logic                          wr_hit;
    bris_pkg::rgb_t                rd_q;

    assign rd_addr = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
    assign wr_hit  = wr_en && (wr_row[0] == b[1]) && (wr_col[0] == b[0]);
    assign rd_data[b] = rd_q;

    always_ff @(posedge clk) begin
      if (wr_hit) begin
        mem[{wr_row[bris_pkg::SRC_AW-1:1], wr_col[bris_pkg::SRC_AW-1:1]}] <= wr_data;
      end
      if (en) begin
        rd_q <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== sv/bris_blend.sv =====
// weights, products and sum of the four neighbors per channel
// depends on bris_pkg; three register stages
module bris_blend (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bris_pkg::FRAC_W-1:0]   dr,
  input  logic [bris_pkg::FRAC_W-1:0]   dc,
  input  logic                          r0,
  input  logic                          c0,
  input  bris_pkg::rgb_t [3:0]          q,
  output bris_pkg::rgb_t                pix
);

  localparam int E_W  = bris_pkg::E_W;
  localparam int WT_W = bris_pkg::WT_W;
  localparam int MW   = 2 * E_W;

  logic signed [E_W-1:0]  er, ec, sdr, sdc;
  logic signed [MW-1:0]   m0, m1, m2, m3;
  logic signed [WT_W-1:0] w [4];
  logic                   r0_q, c0_q;
  logic signed [bris_pkg::PRD_W-1:0] prd [3][4];
  bris_pkg::rgb_t         nb [4];
  logic signed [bris_pkg::SUM_W-1:0] sum [3];
  logic signed [bris_pkg::SUM_W-bris_pkg::FRAC_BITS-1:0] v [3];
  logic [bris_pkg::PIX_W-1:0] ch [3];

  always_comb begin
    sdr = E_W'(dr);
    sdc = E_W'(dc);
    er  = E_W'(1 << bris_pkg::FRAC_BITS) - sdr;
    ec  = E_W'(1 << bris_pkg::FRAC_BITS) - sdc;
    m0  = er * ec;
    m1  = sdr * ec;
    m2  = er * sdc;
    m3  = sdr * sdc;
    nb[0] = q[{r0_q, c0_q}];
    nb[1] = q[{~r0_q, c0_q}];
    nb[2] = q[{r0_q, ~c0_q}];
    nb[3] = q[{~r0_q, ~c0_q}];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w[0] <= m0[bris_pkg::FRAC_BITS +: WT_W];
      w[1] <= m1[bris_pkg::FRAC_BITS +: WT_W];
      w[2] <= m2[bris_pkg::FRAC_BITS +: WT_W];
      w[3] <= m3[bris_pkg::FRAC_BITS +: WT_W];
      r0_q <= r0;
      c0_q <= c0;
      for (int k = 0; k < 4; k++) begin
        prd[0][k] <= $signed({1'b0, nb[k].red})   * w[k];
        prd[1][k] <= $signed({1'b0, nb[k].green}) * w[k];
        prd[2][k] <= $signed({1'b0, nb[k].blue})  * w[k];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = bris_pkg::SUM_W'(prd[j][0]) + bris_pkg::SUM_W'(prd[j][1])
             + bris_pkg::SUM_W'(prd[j][2]) + bris_pkg::SUM_W'(prd[j][3]);
      v[j] = sum[j][bris_pkg::SUM_W-1:bris_pkg::FRAC_BITS];
      if (v[j] < 0) begin
        ch[j] = '0;
      end else if (v[j] > 255) begin
        ch[j] = '1;
      end else begin
        ch[j] = v[j][bris_pkg::PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix.red   <= ch[0];
      pix.green <= ch[1];
      pix.blue  <= ch[2];
    end
  end

endmodule

// ===== sv/bilinear_rgb_image_scaler.sv =====
// Bilinear RGB scaler: load beats (tuser 0) write one in-range source pixel, request beats
// (tuser 1) return one interpolated pixel. A stalled output freezes the whole pipeline;
// otherwise one beat is taken every cycle, loads and requests mixed freely; the four
// neighbors come from four parity banks read together, so throughput is one pixel per clock.
// depends on bris_pkg, bris_axis, bris_mem, bris_blend and assert_macros.svh
`include "assert_macros.svh"

module bilinear_rgb_image_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // row, col, red_in, green_in, blue_in
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red_out, green_out, blue_out
);

  localparam int AW = bris_pkg::SRC_AW;
  localparam int IW = bris_pkg::IDX_W;

  logic [bris_pkg::SIZE_W-1:0] source_width, source_height;
  logic [bris_pkg::STEP_W-1:0] row_step, col_step;

  logic en, acc;
  logic v1, v2, v3, v4;
  logic act1, act2;
  logic ok1, ok2;
  logic [AW-1:0] lrow1, lcol1, lrow2, lcol2;
  bris_pkg::rgb_t ld1, ld2;
  logic [AW-1:0] rip, cip;
  logic [bris_pkg::FRAC_W-1:0] rfr, cfr;
  bris_pkg::rgb_t [3:0] q;
  bris_pkg::rgb_t pix;
  logic [IW-1:0] in_row, in_col;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && s_tready;
  assign in_row   = s_tdata[IW-1:0];
  assign in_col   = s_tdata[2*IW-1:IW];
  assign m_tdata  = {pix.blue, pix.green, pix.red};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= bris_pkg::SIZE_W'(2);
      source_height <= bris_pkg::SIZE_W'(2);
      row_step      <= bris_pkg::STEP_W'(1 << bris_pkg::FRAC_BITS);
      col_step      <= bris_pkg::STEP_W'(1 << bris_pkg::FRAC_BITS);
    end else if (cfg_wr_en) begin
      unique case (bris_pkg::cfg_reg_t'(cfg_index))
        bris_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[bris_pkg::SIZE_W-1:0];
        bris_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[bris_pkg::SIZE_W-1:0];
        bris_pkg::REG_ROW_STEP:      row_step      <= cfg_data;
        bris_pkg::REG_COL_STEP:      col_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2 && (act2 == bris_pkg::ACT_REQUEST);
      v4 <= v3;
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1  <= s_tuser[0];
      ok1   <= (in_row[IW-1:AW] == '0) && (in_col[IW-1:AW] == '0);
      lrow1 <= in_row[AW-1:0];
      lcol1 <= in_col[AW-1:0];
      ld1   <= '{red:   s_tdata[2*IW +: 8],
                 green: s_tdata[2*IW+8 +: 8],
                 blue:  s_tdata[2*IW+16 +: 8]};
      act2  <= act1;
      ok2   <= ok1;
      lrow2 <= lrow1;
      lcol2 <= lcol1;
      ld2   <= ld1;
    end
  end

  bris_axis u_row_axis (
    .clk   (clk),
    .en    (en),
    .index (in_row),
    .step  (row_step),
    .lim   (bris_pkg::eff_lim(source_height)),
    .ip    (rip),
    .frac  (rfr)
  );

  bris_axis u_col_axis (
    .clk   (clk),
    .en    (en),
    .index (in_col),
    .step  (col_step),
    .lim   (bris_pkg::eff_lim(source_width)),
    .ip    (cip),
    .frac  (cfr)
  );

  bris_mem u_mem (
    .clk     (clk),
    .en      (en),
    .wr_en   (en && v2 && (act2 == bris_pkg::ACT_LOAD) && ok2),
    .wr_row  (lrow2),
    .wr_col  (lcol2),
    .wr_data (ld2),
    .rd_row  (rip),
    .rd_col  (cip),
    .rd_data (q)
  );

  bris_blend u_blend (
    .clk (clk),
    .en  (en),
    .dr  (rfr),
    .dc  (cfr),
    .r0  (rip[0]),
    .c0  (cip[0]),
    .q   (q),
    .pix (pix)
  );

  `BRIS_ASSERT_NEXT(a_req_reaches_out, en && v4, m_tvalid, "request lost before output")
  `BRIS_ASSERT_NEXT(a_no_phantom_out, en && !v4, !m_tvalid, "output without a request")
  `BRIS_ASSERT_NEXT(a_stall_freezes, !en, $stable(v4) && $stable(v3), "pipeline moved in stall")

endmodule

// ===== sim/tb.sv =====
// testbench for bilinear_rgb_image_scaler: loads source images, requests scaled pixels and
// checks each output beat against a behavioral interpolation model kept in this file
// depends on bris_pkg and the scaler rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bris_pkg::action_t act;
    logic [11:0]       row;
    logic [11:0]       col;
    bris_pkg::rgb_t    pix;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  bilinear_rgb_image_scaler dut (.*);

  always #5 clk = ~clk;

  beat_t          pending[$];
  bris_pkg::rgb_t scaled_pixels[$];
  beat_t          cur;
  logic [23:0] src_store [0:65535];
  int unsigned src_w = 2, src_h = 2;
  longint     row_step = 65536, col_step = 65536;
  int         errors = 0;
  int         hold_left = 0;
  bit         calm = 1'b0;
  longint     cycles = 0;

  function automatic int unsigned eff_size(int unsigned s);
    if (s < 2) return 2;
    if (s > bris_pkg::SRC_DIM) return bris_pkg::SRC_DIM;
    return s;
  endfunction

  function automatic void split_axis(longint idx, longint step, int unsigned sz,
                                     output longint ip, output longint fr);
    longint pos;
    pos = idx * step;
    ip = pos >>> 16;
    if (ip > sz - 2) ip = sz - 2;
    fr = pos - (ip << 16);
    if (fr > 131071) fr = 131071;
  endfunction

  function automatic bris_pkg::rgb_t interpolate(logic [11:0] row, logic [11:0] col);
    longint r, c, dr, dc, er, ec, sum, v;
    longint w[4];
    logic [23:0] p[4];
    bris_pkg::rgb_t res;
    split_axis(row, row_step, eff_size(src_h), r, dr);
    split_axis(col, col_step, eff_size(src_w), c, dc);
    er = 65536 - dr;
    ec = 65536 - dc;
    w[0] = (er * ec) >>> 16;
    w[1] = (dr * ec) >>> 16;
    w[2] = (er * dc) >>> 16;
    w[3] = (dr * dc) >>> 16;
    p[0] = src_store[16'(r * 256 + c)];
    p[1] = src_store[16'((r + 1) * 256 + c)];
    p[2] = src_store[16'(r * 256 + c + 1)];
    p[3] = src_store[16'((r + 1) * 256 + c + 1)];
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int j = 0; j < 4; j++) sum += longint'((p[j] >> (16 - 8 * k)) & 8'hff) * w[j];
      v = sum >>> 16;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      res[23 - 8 * k -: 8] = v[7:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst && (!s_tvalid || s_tready)) begin
      if (s_tvalid) begin
        if (cur.act == bris_pkg::ACT_LOAD) begin
          if (cur.row < 256 && cur.col < 256) src_store[{cur.row[7:0], cur.col[7:0]}] = cur.pix;
        end else begin
          scaled_pixels.push_back(interpolate(cur.row, cur.col));
        end
      end
      if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
        cur = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur.act;
        s_tdata  <= {cur.pix.blue, cur.pix.green, cur.pix.red, cur.col, cur.row};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) if (hold_left > 0) hold_left <= hold_left - 1;

  // monitor
  always @(posedge clk) begin
    bris_pkg::rgb_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
      if (scaled_pixels.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = scaled_pixels.pop_front();
        if (want.red !== got.red)
          $display("%0t red: expected %h, actual %h", $time, want.red, got.red);
        if (want.green !== got.green)
          $display("%0t green: expected %h, actual %h", $time, want.green, got.green);
        if (want.blue !== got.blue)
          $display("%0t blue: expected %h, actual %h", $time, want.blue, got.blue);
        if (want !== got) errors++;
      end
    end
    m_tready <= !rst && hold_left <= 1 && (calm || $urandom_range(0, 99) >= 36);
  end

  task automatic drain();
    while (pending.size() > 0 || s_tvalid || scaled_pixels.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic push(bris_pkg::action_t a, int unsigned r, int unsigned c, bris_pkg::rgb_t p);
    beat_t b;
    b.act = a;
    b.row = 12'(r);
    b.col = 12'(c);
    b.pix = p;
    pending.push_back(b);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned rs, int unsigned cs,
                           int nreq, bit write_cfg);
    int unsigned ew, eh, rr, cc;
    logic [23:0] vals[4];
    drain();
    if (write_cfg) begin
      vals = '{24'(w), 24'(h), 24'(rs), 24'(cs)};
      for (int i = 0; i < 4; i++) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= bris_pkg::cfg_reg_t'(i);
        cfg_data  <= vals[i];
        @(posedge clk);
      end
      cfg_wr_en <= 1'b0;
      src_w = w;
      src_h = h;
      row_step = rs;
      col_step = cs;
    end
    ew = eff_size(w);
    eh = eff_size(h);
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++) push(bris_pkg::ACT_LOAD, r, c, bris_pkg::rgb_t'($urandom));
    for (int i = 0; i < nreq; i++) begin
      if (i == nreq / 2) begin
        while (pending.size() > 0) @(posedge clk);
        drain();
      end
      case ($urandom_range(0, 9))
        0: push(bris_pkg::ACT_LOAD, $urandom_range(0, eh - 1), $urandom_range(0, ew - 1),
                bris_pkg::rgb_t'($urandom));
        1: push(bris_pkg::ACT_LOAD, $urandom_range(256, 4095), $urandom_range(0, 4095),
                bris_pkg::rgb_t'($urandom));
        2: push(bris_pkg::ACT_LOAD, $urandom_range(0, 255), $urandom_range(256, 4095),
                bris_pkg::rgb_t'($urandom));
        3, 4: push(bris_pkg::ACT_REQUEST, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   bris_pkg::rgb_t'($urandom));
        default: begin
          rr = $urandom_range(0, 2 * eh);
          cc = $urandom_range(0, 2 * ew);
          push(bris_pkg::ACT_REQUEST, rr, cc, bris_pkg::rgb_t'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset configuration, extreme pixels and positions
    push(bris_pkg::ACT_LOAD, 0, 0, 24'h000000);
    push(bris_pkg::ACT_LOAD, 0, 1, 24'hffffff);
    push(bris_pkg::ACT_LOAD, 1, 0, 24'hff00ff);
    push(bris_pkg::ACT_LOAD, 1, 1, 24'h00ff00);
    push(bris_pkg::ACT_LOAD, 4095, 4095, 24'h123456);
    push(bris_pkg::ACT_LOAD, 255, 4095, 24'habcdef);
    push(bris_pkg::ACT_REQUEST, 0, 0, 24'hffffff);
    push(bris_pkg::ACT_REQUEST, 0, 1, 24'h0);
    push(bris_pkg::ACT_REQUEST, 1, 0, 24'h0);
    push(bris_pkg::ACT_REQUEST, 1, 1, 24'h0);
    push(bris_pkg::ACT_REQUEST, 2, 3, 24'h0);
    push(bris_pkg::ACT_REQUEST, 4095, 0, 24'h0);
    push(bris_pkg::ACT_REQUEST, 0, 4095, 24'h0);
    push(bris_pkg::ACT_REQUEST, 4095, 4095, 24'hffffff);
    run_phase(2, 2, 65536, 65536, 0, 1'b0);
    run_phase(0, 1, 0, 24'h800000, 120, 1'b1);
    calm = 1'b1;
    run_phase(5, 7, 24'h00c000, 24'h018000, 180, 1'b1);
    // long output stall while input keeps coming
    hold_left = 400;
    run_phase(511, 2, 24'hffffff, 24'h008000, 80, 1'b1);
    drain();
    calm = 1'b0;
    run_phase(2, 300, 24'h00ff00, 24'h000001, 80, 1'b1);
    run_phase(16, 9, $urandom_range(0, 24'hffffff), $urandom_range(0, 24'h30000), 100, 1'b1);
    run_phase(3, 20, $urandom_range(0, 24'h40000), $urandom_range(0, 24'hffffff), 100, 1'b1);
    drain();
    if (errors == 0 && scaled_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/bris_pkg.sv
sv/bris_axis.sv
sv/bris_mem.sv
sv/bris_blend.sv
sv/bilinear_rgb_image_scaler.sv
sim/tb.sv
